// ===== sv/fbd_pkg.sv =====
// Shared constants and types for the framed bit deframer.
package fbd_pkg;

  localparam int unsigned HDR_W    = 6;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BIDX_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [HDR_W-1:0]   HDR_ONES_RST  = 6'd16;
  localparam logic [HDR_W-1:0]   ONES_RUN_MAX  = 6'd63;
  localparam logic [LIMIT_W-1:0] MAX_BYTES_RST = 12'd500;
  localparam logic [BYTE_W-1:0]  TRAILER_HI    = 8'hFF;
  localparam logic [BYTE_W-1:0]  TRAILER_LO    = 8'hFE;
  localparam logic [BIDX_W-1:0]  BIDX_LAST     = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_ONES     = 1'b0,
    CFG_MAX_FRAME_BYTES = 1'b1
  } cfg_idx_t;

endpackage

// ===== sv/fbd_if.sv =====
// Valid/ready channel interfaces for line bits in and deframed results out.
interface fbd_in_if;
  logic valid;
  logic ready;
  logic line_bit;

  modport source (output valid, output line_bit, input ready);
  modport sink   (input valid, input line_bit, output ready);
endinterface

interface fbd_out_if;
  logic       valid;
  logic       ready;
  logic       echo_bit;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       frame_end;
  logic       frame_abort;
  logic       in_frame;

  modport source (output valid, output echo_bit, output data_valid, output data_byte,
                  output frame_end, output frame_abort, output in_frame, input ready);
  modport sink   (input valid, input echo_bit, input data_valid, input data_byte,
                  input frame_end, input frame_abort, input in_frame, output ready);
endinterface

// ===== sv/framed_bit_deframer.sv =====
// Framed bit deframer: header hunt, byte assembly, trailer detection.
//
// Usage: each item on in_ch carries one sampled line bit. While hunting, the
// block counts consecutive ones; a run of header_ones enters a frame. In a
// frame every bit is echoed and bytes are assembled MSB first. A completed
// byte is held back and emitted when the next one completes, so a
// trailer FF FE closes the frame without appearing on the output. A byte that
// completes with max_frame_bytes already received aborts the frame.
// Every accepted item yields exactly one result item on out_ch.
// Latency: the result is valid the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; all work is a single
// compare/increment stage between the frame state and result registers.
// Receiver stall: the result register holds its item; in_ch.ready stays high
// as long as that register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): hunting, counters cleared, header_ones=16,
// max_frame_bytes=500, no result pending. Configuration writes (cfg_we,
// cfg_idx, cfg_wdata) take effect at once and belong in idle periods.
module framed_bit_deframer
  import fbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fbd_in_if.sink                in_ch,
  fbd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [HDR_W-1:0]   header_ones_r;
  logic [LIMIT_W-1:0] max_bytes_r;

  logic [HDR_W-1:0]   ones_run_r,   ones_run_nxt;
  logic               framing_r,    framing_nxt;
  logic [BIDX_W-1:0]  bit_index_r,  bit_index_nxt;
  logic [BYTE_W-1:0]  shift_bits_r, shift_bits_nxt;
  logic [BYTE_W-1:0]  held_byte_r,  held_byte_nxt;
  logic [LIMIT_W-1:0] bytes_seen_r, bytes_seen_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               echo_r,  echo_nxt;
  logic               dvalid_r, dvalid_nxt;
  logic [BYTE_W-1:0]  dbyte_r, dbyte_nxt;
  logic               fend_r,  fend_nxt;
  logic               fabort_r, fabort_nxt;

  logic               accept;
  logic [HDR_W-1:0]   need;
  logic [HDR_W-1:0]   run_upd;
  logic [BYTE_W-1:0]  byte_asm;
  logic               is_trailer;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // zero header length behaves as one
  assign need     = (header_ones_r == '0) ? HDR_W'(1) : header_ones_r;
  assign byte_asm = {shift_bits_r[BYTE_W-2:0], in_ch.line_bit};
  assign is_trailer = (bytes_seen_r != '0) && (held_byte_r == TRAILER_HI) &&
                      (byte_asm == TRAILER_LO);

  always_comb begin
    if (!in_ch.line_bit) begin
      run_upd = '0;
    end else if (ones_run_r < ONES_RUN_MAX) begin
      run_upd = ones_run_r + HDR_W'(1);
    end else begin
      run_upd = ones_run_r;
    end
  end

  always_comb begin
    ones_run_nxt   = ones_run_r;
    framing_nxt    = framing_r;
    bit_index_nxt  = bit_index_r;
    shift_bits_nxt = shift_bits_r;
    held_byte_nxt  = held_byte_r;
    bytes_seen_nxt = bytes_seen_r;
    echo_nxt       = 1'b0;
    dvalid_nxt     = 1'b0;
    dbyte_nxt      = '0;
    fend_nxt       = 1'b0;
    fabort_nxt     = 1'b0;
    if (framing_r) begin
      echo_nxt       = in_ch.line_bit;
      shift_bits_nxt = byte_asm;
      if (bit_index_r == BIDX_LAST) begin
        bit_index_nxt = '0;
        if (is_trailer) begin
          fend_nxt    = 1'b1;
          framing_nxt = 1'b0;
        end else if (bytes_seen_r >= max_bytes_r) begin
          fabort_nxt     = 1'b1;
          framing_nxt    = 1'b0;
          bytes_seen_nxt = '0;
        end else begin
          if (bytes_seen_r != '0) begin
            dvalid_nxt = 1'b1;
            dbyte_nxt  = held_byte_r;
          end
          held_byte_nxt  = byte_asm;
          bytes_seen_nxt = bytes_seen_r + LIMIT_W'(1);
        end
      end else begin
        bit_index_nxt = bit_index_r + BIDX_W'(1);
      end
    end else begin
      ones_run_nxt = run_upd;
      if (run_upd == need) begin
        framing_nxt    = 1'b1;
        ones_run_nxt   = '0;
        bit_index_nxt  = '0;
        shift_bits_nxt = '0;
        held_byte_nxt  = '0;
        bytes_seen_nxt = '0;
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_ones_r <= HDR_ONES_RST;
      max_bytes_r   <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_HEADER_ONES:     header_ones_r <= cfg_wdata[HDR_W-1:0];
        CFG_MAX_FRAME_BYTES: max_bytes_r   <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_run_r   <= '0;
      framing_r    <= 1'b0;
      bit_index_r  <= '0;
      shift_bits_r <= '0;
      held_byte_r  <= '0;
      bytes_seen_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        ones_run_r   <= ones_run_nxt;
        framing_r    <= framing_nxt;
        bit_index_r  <= bit_index_nxt;
        shift_bits_r <= shift_bits_nxt;
        held_byte_r  <= held_byte_nxt;
        bytes_seen_r <= bytes_seen_nxt;
      end
    end
  end

  // result payload, loaded only with an accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_r   <= echo_nxt;
      dvalid_r <= dvalid_nxt;
      dbyte_r  <= dbyte_nxt;
      fend_r   <= fend_nxt;
      fabort_r <= fabort_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.echo_bit    = echo_r;
  assign out_ch.data_valid  = dvalid_r;
  assign out_ch.data_byte   = dbyte_r;
  assign out_ch.frame_end   = fend_r;
  assign out_ch.frame_abort = fabort_r;
  assign out_ch.in_frame    = framing_r;

  // in_frame comes from the live state; it must match the result held
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !accept)
    else $error("item accepted while result stalled");

  a_end_abort_excl: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !(fend_r && fabort_r))
    else $error("frame end and abort in one item");

  a_data_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (!dvalid_r || framing_r))
    else $error("data byte emitted outside a frame");

  a_close_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (!(fend_r || fabort_r) || !framing_r))
    else $error("still framing after frame close");

  a_hunt_bidx: assert property (@(posedge clk) disable iff (!rst_n)
    !framing_r |-> (bit_index_r == '0))
    else $error("bit index nonzero while hunting");

endmodule

// ===== verif/framed_bit_deframer_chk.sv =====
// Checker for the framed bit deframer: tracks frame state, predicts each result and compares.
`timescale 1ns / 100ps

module framed_bit_deframer_chk
  import fbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fbd_in_if                     in_ch,
  fbd_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic              echo_bit;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
    logic              frame_abort;
    logic              in_frame;
  } deframe_res_t;

  logic [HDR_W-1:0]   hdr_ones   = HDR_ONES_RST;
  logic [LIMIT_W-1:0] byte_limit = MAX_BYTES_RST;
  logic [HDR_W-1:0]   run_len    = '0;
  logic               framing    = 1'b0;
  logic [BIDX_W-1:0]  bit_pos    = '0;
  logic [BYTE_W-1:0]  shreg      = '0;
  logic [BYTE_W-1:0]  held       = '0;
  logic [LIMIT_W-1:0] byte_cnt   = '0;

  deframe_res_t expected_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic deframe_res_t deframe_bit(input logic b);
    deframe_res_t     r;
    logic [HDR_W-1:0] need;
    r = '0;
    if (framing) begin
      r.echo_bit = b;
      shreg = {shreg[BYTE_W-2:0], b};
      if (bit_pos == BIDX_LAST) begin
        bit_pos = '0;
        // no byte precedes the first one, so it can never close a trailer
        if (byte_cnt != '0 && held == TRAILER_HI && shreg == TRAILER_LO) begin
          r.frame_end = 1'b1;
          framing     = 1'b0;
        end else if (byte_cnt >= byte_limit) begin
          r.frame_abort = 1'b1;
          framing       = 1'b0;
          byte_cnt      = '0;
        end else begin
          if (byte_cnt != '0) begin
            r.data_valid = 1'b1;
            r.data_byte  = held;
          end
          held     = shreg;
          byte_cnt = byte_cnt + 1'b1;
        end
      end else begin
        bit_pos = bit_pos + 1'b1;
      end
    end else begin
      need = (hdr_ones == '0) ? HDR_W'(1) : hdr_ones;
      if (b) begin
        if (run_len != ONES_RUN_MAX) run_len = run_len + 1'b1;
      end else begin
        run_len = '0;
      end
      if (run_len == need) begin
        framing  = 1'b1;
        run_len  = '0;
        bit_pos  = '0;
        shreg    = '0;
        held     = '0;
        byte_cnt = '0;
      end
    end
    r.in_frame = framing;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    deframe_res_t got;
    deframe_res_t want;
    if (!rst_n) begin
      hdr_ones   = HDR_ONES_RST;
      byte_limit = MAX_BYTES_RST;
      run_len    = '0;
      framing    = 1'b0;
      bit_pos    = '0;
      shreg      = '0;
      held       = '0;
      byte_cnt   = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_HEADER_ONES) hdr_ones = cfg_wdata[HDR_W-1:0];
        else byte_limit = cfg_wdata[LIMIT_W-1:0];
      end
      // drain before predicting: a result never leaves in the cycle its bit arrives
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.echo_bit, out_ch.data_valid, out_ch.data_byte,
                out_ch.frame_end, out_ch.frame_abort, out_ch.in_frame};
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("echo_bit", 8'(want.echo_bit), 8'(got.echo_bit));
          check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
          check_field("frame_abort", 8'(want.frame_abort), 8'(got.frame_abort));
          check_field("in_frame", 8'(want.in_frame), 8'(got.in_frame));
        end
      end
      if (in_ch.valid && in_ch.ready) expected_q.push_back(deframe_bit(in_ch.line_bit));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== verif/framed_bit_deframer_tb.sv =====
// Testbench top for the framed bit deframer: clock, reset, line bit stimulus and verdict.
`timescale 1ns / 100ps

module framed_bit_deframer_tb;
  import fbd_pkg::*;

  localparam int N_PHASES = 8;
  localparam int LIMIT    = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int errors;
  int pending;
  int cycles     = 0;
  int bits_sent  = 0;
  int stall_left = 0;
  int hdr_cur    = int'(HDR_ONES_RST);
  int lim_cur    = int'(MAX_BYTES_RST);
  bit idle_on    = 1'b0;
  logic rcv_ready = 1'b1;

  fbd_in_if  in_ch ();
  fbd_out_if out_ch ();

  assign out_ch.ready = rcv_ready;

  framed_bit_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  framed_bit_deframer_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("framed_bit_deframer test failed");
      $finish;
    end
  end

  // receiver stalls in bursts of random length while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rcv_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rcv_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      rcv_ready <= 1'b1;
    end
  end

  task automatic send_bit(input logic b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.line_bit <= b;
    do @(posedge clk); while (!in_ch.ready);
    bits_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_bit(b[i]);
  endtask

  // leading zeros, header run, payload bytes with trailer-like values mixed in, optional trailer
  task automatic send_frame(input bit closed);
    int n;
    int need;
    int cap;
    logic [7:0] b;
    need = (hdr_cur == 0) ? 1 : hdr_cur;
    cap  = (lim_cur < 8) ? lim_cur : 8;
    n    = $urandom_range(0, cap);
    if (lim_cur <= 12 && $urandom_range(0, 5) == 0) n = lim_cur + $urandom_range(1, 2);
    repeat ($urandom_range(1, 2)) send_bit(1'b0);
    repeat (need) send_bit(1'b1);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       b = TRAILER_HI;
        1:       b = TRAILER_LO;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
    if (closed) begin
      send_byte(TRAILER_HI);
      send_byte(TRAILER_LO);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_regs(input int hdr, input int lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HEADER_ONES;
    cfg_wdata <= CFG_DATA_W'(hdr);
    @(posedge clk);
    cfg_idx   <= CFG_MAX_FRAME_BYTES;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(posedge clk);
    cfg_we  <= 1'b0;
    hdr_cur = hdr;
    lim_cur = lim;
  endtask

  initial begin
    int hdr_tab[N_PHASES];
    int lim_tab[N_PHASES];
    int budget[N_PHASES];
    int start;
    int kind;
    hdr_tab = '{1, 16, 63, 0, 5, 1, 1, 2};
    lim_tab = '{2, 500, 4095, 0, 3, 1, 1, 1};
    budget  = '{110, 130, 350, 110, 130, 130, 130, 130};
    hdr_tab[5] = $urandom_range(1, 20);
    lim_tab[5] = $urandom_range(1, 12);
    hdr_tab[6] = $urandom_range(1, 63);
    lim_tab[6] = $urandom_range(1, 4095);

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.line_bit <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_HEADER_ONES;
    cfg_wdata      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      set_regs(hdr_tab[ph], lim_tab[ph]);
      if (ph == 0) begin
        // one-bit header; first byte FE must not close, then FF FE closes with limit reached
        send_bit(1'b1);
        send_byte(TRAILER_LO);
        send_byte(TRAILER_HI);
        send_byte(TRAILER_LO);
      end
      start = bits_sent;
      while (bits_sent - start < budget[ph]) begin
        idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          send_frame(1'b1);
        end else if (kind == 7) begin
          send_frame(1'b0);
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 24)) send_bit(1'($urandom_range(0, 1)));
        end else begin
          // long ones run of 1 to 70 bits; a run reaching the header length enters a frame
          repeat ($urandom_range(1, 70)) send_bit(1'b1);
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("framed_bit_deframer test passed");
    end else begin
      $display("framed_bit_deframer test failed");
    end
    $finish;
  end

endmodule
